[rtl/bpa_pkg.sv]
// Shared types and constants for the buddy page allocator.
package bpa_pkg;

    localparam int REQ_W      = 2;
    localparam int ST_W       = 2;
    localparam int PAGE_W     = 12;
    localparam int LEVEL_W    = 4;
    localparam int BYTES_W    = 25;
    localparam int HEAP_W     = 12;
    localparam int PAGE_SHIFT = 12;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

    localparam logic [HEAP_W-1:0] HEAP_RESET = 12'd256;

    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_INIT  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_ZERO = 2'd1;
    localparam logic [ST_W-1:0] ST_OOM  = 2'd2;
    localparam logic [ST_W-1:0] ST_IGN  = 2'd3;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLR_START,
        OP_CLR_STEP,
        OP_BLK_START,
        OP_BLK_SETUP,
        OP_BLK_NEXT,
        OP_SCAN_UP,
        OP_TAKE,
        OP_UL1,
        OP_UL1M,
        OP_UL2,
        OP_UL2P,
        OP_UL2M,
        OP_SPLIT,
        OP_PUSH1,
        OP_PUSHB1,
        OP_PUSH2,
        OP_RD_PG,
        OP_FMARK,
        OP_RD_BD
    } dp_op_t;

    typedef struct packed {
        dp_op_t           op;
        logic             emit;
        logic [ST_W-1:0]  st;
    } dp_cmd_t;

    typedef struct packed {
        logic              cnt_end;
        logic [REQ_W-1:0]  kind;
        logic              zero;
        logic              over;
        logic              pn_ok;
        logic              head_valid;
        logic              lv_top;
        logic              lv_gt_want;
        logic              split_bd_ok;
        logic              rd_free;
        logic              merge_ok;
        logic              free_bd_ok;
        logic              out_free;
    } dp_sts_t;

endpackage

[rtl/bpa_datapath.sv]
// Page tables, free-list heads, work registers and result register.
module bpa_datapath #(
    parameter int NUM_PAGES = 4096,
    parameter int TOP_LEVEL = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  bpa_pkg::dp_cmd_t                cmd,
    output bpa_pkg::dp_sts_t                sts,
    input  logic [bpa_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic [bpa_pkg::REQ_W-1:0]       s_tuser,
    input  logic                            cfg_valid,
    input  logic [bpa_pkg::HEAP_W-1:0]      cfg_data,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [bpa_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic [bpa_pkg::ST_W-1:0]        m_tuser
);

    localparam int PW = $clog2(NUM_PAGES);
    localparam int AW = PW + 1;
    localparam int LW = $clog2(TOP_LEVEL + 1);
    localparam int CW = (AW > bpa_pkg::HEAP_W) ? AW : bpa_pkg::HEAP_W;
    localparam int HN = TOP_LEVEL + 1;
    localparam logic [AW-1:0] NIL = AW'(NUM_PAGES);

    logic             free_mem  [NUM_PAGES];
    logic [LW-1:0]    level_mem [NUM_PAGES];
    logic [AW-1:0]    next_mem  [NUM_PAGES];
    logic [AW-1:0]    prev_mem  [NUM_PAGES];
    logic [AW-1:0]    head_reg  [HN];

    logic [bpa_pkg::HEAP_W-1:0]  heap_reg;
    logic [CW-1:0]               cnt_reg;
    logic [bpa_pkg::REQ_W-1:0]   kind_reg;
    logic [LW-1:0]               want_reg;
    logic                        zero_reg;
    logic                        over_reg;
    logic                        pn_ok_reg;
    logic [AW-1:0]               pg_reg;
    logic [AW-1:0]               bd_reg;
    logic [AW-1:0]               ux_reg;
    logic [LW-1:0]               lv_reg;
    logic [AW-1:0]               h_reg;
    logic [AW-1:0]               t_reg;
    logic                        rd_free_reg;
    logic [LW-1:0]               rd_level_reg;
    logic [AW-1:0]               rd_next_reg;
    logic [AW-1:0]               rd_prev_reg;
    logic                        out_valid_reg;
    logic [bpa_pkg::ST_W-1:0]    out_status_reg;
    logic [bpa_pkg::PAGE_W-1:0]  out_page_reg;
    logic [bpa_pkg::LEVEL_W-1:0] out_level_reg;

    logic [bpa_pkg::BYTES_W-1:0] in_bytes;
    logic [bpa_pkg::PAGE_W-1:0]  in_page;
    logic [bpa_pkg::BYTES_W:0]   bytes_sum;
    logic [14:0]                 pages_w;
    logic [LW-1:0]               want_c;
    logic                        over_c;
    logic                        pn_ok_c;
    logic [LW-1:0]               init_lv_c;
    logic [AW-1:0]               head_cur;
    logic [31:0]                 fbd32;
    logic [31:0]                 sbd32;
    logic [LW-1:0]               lv_dec;
    logic [AW-1:0]               mn;
    logic [AW-1:0]               mx;
    logic                        out_free;

    logic             free_we,  level_we,  next_we,  prev_we, rd_en;
    logic [PW-1:0]    free_wa,  level_wa,  next_wa,  prev_wa, rd_a;
    logic             free_wd;
    logic [LW-1:0]    level_wd;
    logic [AW-1:0]    next_wd,  prev_wd;

    function automatic logic pg_ok(input logic [AW-1:0] x);
        return 32'(x) < NUM_PAGES;
    endfunction

    assign in_bytes  = s_tdata[bpa_pkg::BYTES_W-1:0];
    assign in_page   = s_tdata[bpa_pkg::BYTES_W +: bpa_pkg::PAGE_W];
    assign bytes_sum = (bpa_pkg::BYTES_W+1)'(in_bytes)
                     + (bpa_pkg::BYTES_W+1)'((1 << bpa_pkg::PAGE_SHIFT) - 1);
    assign pages_w   = 15'(bytes_sum >> bpa_pkg::PAGE_SHIFT);
    assign pn_ok_c   = (in_page >= heap_reg) && (32'(in_page) < NUM_PAGES);

    always_comb
    begin
        want_c = '0;
        over_c = 1'b1;
        for (int k = TOP_LEVEL; k >= 0; k--)
        begin
            if ((32'd1 << k) >= 32'(pages_w))
            begin
                want_c = LW'(k);
                over_c = 1'b0;
            end
        end
    end

    // largest aligned block at cnt that still fits below the page count
    always_comb
    begin
        init_lv_c = '0;
        for (int k = 0; k <= TOP_LEVEL; k++)
        begin
            if ((32'(cnt_reg) & ((32'd1 << k) - 32'd1)) == 32'd0 &&
                32'(cnt_reg) + (32'd1 << k) <= NUM_PAGES)
                init_lv_c = LW'(k);
        end
    end

    assign head_cur = head_reg[lv_reg];
    assign lv_dec   = lv_reg - LW'(1);
    assign fbd32    = 32'(pg_reg) ^ (32'd1 << lv_reg);
    assign sbd32    = 32'(pg_reg) + (32'd1 << lv_dec);
    assign mn       = (ux_reg < pg_reg) ? ux_reg : pg_reg;
    assign mx       = (ux_reg < pg_reg) ? pg_reg : ux_reg;
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        free_we  = 1'b0;  free_wa  = '0;  free_wd  = 1'b0;
        level_we = 1'b0;  level_wa = '0;  level_wd = '0;
        next_we  = 1'b0;  next_wa  = '0;  next_wd  = NIL;
        prev_we  = 1'b0;  prev_wa  = '0;  prev_wd  = NIL;
        rd_en    = 1'b0;  rd_a     = '0;
        case (cmd.op)
            bpa_pkg::OP_CLR_STEP:
            begin
                free_we  = 1'b1;
                free_wa  = cnt_reg[PW-1:0];
                free_wd  = 32'(cnt_reg) >= 32'(heap_reg);
                level_we = 1'b1;
                level_wa = cnt_reg[PW-1:0];
                next_we  = 1'b1;
                next_wa  = cnt_reg[PW-1:0];
                prev_we  = 1'b1;
                prev_wa  = cnt_reg[PW-1:0];
            end
            bpa_pkg::OP_TAKE:
            begin
                rd_en = 1'b1;
                rd_a  = head_cur[PW-1:0];
            end
            bpa_pkg::OP_UL1, bpa_pkg::OP_UL1M:
            begin
                prev_we = pg_ok(rd_next_reg);
                prev_wa = rd_next_reg[PW-1:0];
                prev_wd = rd_prev_reg;
                next_we = pg_ok(rd_prev_reg);
                next_wa = rd_prev_reg[PW-1:0];
                next_wd = rd_next_reg;
                if (cmd.op == bpa_pkg::OP_UL1M)
                begin
                    level_we = 1'b1;
                    level_wa = mx[PW-1:0];
                end
            end
            bpa_pkg::OP_UL2, bpa_pkg::OP_UL2P, bpa_pkg::OP_UL2M:
            begin
                next_we = 1'b1;
                next_wa = ux_reg[PW-1:0];
                prev_we = 1'b1;
                prev_wa = ux_reg[PW-1:0];
                if (cmd.op == bpa_pkg::OP_UL2P)
                begin
                    free_we = 1'b1;
                    free_wa = ux_reg[PW-1:0];
                end
                if (cmd.op == bpa_pkg::OP_UL2M)
                begin
                    level_we = 1'b1;
                    level_wa = mn[PW-1:0];
                    level_wd = lv_reg + LW'(1);
                end
            end
            bpa_pkg::OP_PUSH1:
            begin
                next_we  = 1'b1;
                next_wa  = pg_reg[PW-1:0];
                next_wd  = head_cur;
                prev_we  = 1'b1;
                prev_wa  = pg_reg[PW-1:0];
                level_we = 1'b1;
                level_wa = pg_reg[PW-1:0];
                level_wd = lv_reg;
            end
            bpa_pkg::OP_PUSHB1:
            begin
                next_we  = 1'b1;
                next_wa  = bd_reg[PW-1:0];
                next_wd  = head_cur;
                prev_we  = 1'b1;
                prev_wa  = bd_reg[PW-1:0];
                level_we = 1'b1;
                level_wa = bd_reg[PW-1:0];
                level_wd = lv_reg;
                free_we  = 1'b1;
                free_wa  = bd_reg[PW-1:0];
                free_wd  = 1'b1;
            end
            bpa_pkg::OP_PUSH2:
            begin
                prev_we = pg_ok(h_reg);
                prev_wa = h_reg[PW-1:0];
                prev_wd = t_reg;
            end
            bpa_pkg::OP_RD_PG:
            begin
                rd_en = 1'b1;
                rd_a  = pg_reg[PW-1:0];
            end
            bpa_pkg::OP_FMARK:
            begin
                free_we = 1'b1;
                free_wa = pg_reg[PW-1:0];
                free_wd = 1'b1;
            end
            bpa_pkg::OP_RD_BD:
            begin
                rd_en = 1'b1;
                rd_a  = fbd32[PW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (free_we)
            free_mem[free_wa] <= free_wd;
        if (rd_en)
            rd_free_reg <= free_mem[rd_a];
    end

    always_ff @(posedge clk)
    begin
        if (level_we)
            level_mem[level_wa] <= level_wd;
        if (rd_en)
            rd_level_reg <= level_mem[rd_a];
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
            next_mem[next_wa] <= next_wd;
        if (rd_en)
            rd_next_reg <= next_mem[rd_a];
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
            prev_mem[prev_wa] <= prev_wd;
        if (rd_en)
            rd_prev_reg <= prev_mem[rd_a];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_reg      <= bpa_pkg::HEAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                heap_reg <= cfg_data;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            bpa_pkg::OP_LOAD:
            begin
                kind_reg  <= s_tuser;
                want_reg  <= want_c;
                zero_reg  <= (in_bytes == '0);
                over_reg  <= over_c;
                pn_ok_reg <= pn_ok_c;
                pg_reg    <= AW'(in_page);
                lv_reg    <= want_c;
            end
            bpa_pkg::OP_CLR_START:
            begin
                cnt_reg <= '0;
                for (int i = 0; i < HN; i++)
                    head_reg[i] <= NIL;
            end
            bpa_pkg::OP_CLR_STEP:
                cnt_reg <= cnt_reg + CW'(1);
            bpa_pkg::OP_BLK_START:
                cnt_reg <= CW'(heap_reg);
            bpa_pkg::OP_BLK_SETUP:
            begin
                pg_reg <= AW'(cnt_reg);
                lv_reg <= init_lv_c;
            end
            bpa_pkg::OP_BLK_NEXT:
                cnt_reg <= cnt_reg + CW'(32'd1 << lv_reg);
            bpa_pkg::OP_SCAN_UP:
                lv_reg <= lv_reg + LW'(1);
            bpa_pkg::OP_TAKE:
            begin
                pg_reg <= head_cur;
                ux_reg <= head_cur;
            end
            bpa_pkg::OP_UL1, bpa_pkg::OP_UL1M:
            begin
                if (!pg_ok(rd_prev_reg))
                    head_reg[lv_reg] <= rd_next_reg;
            end
            bpa_pkg::OP_UL2M:
            begin
                pg_reg <= mn;
                lv_reg <= lv_reg + LW'(1);
            end
            bpa_pkg::OP_SPLIT:
            begin
                lv_reg <= lv_dec;
                bd_reg <= AW'(sbd32);
            end
            bpa_pkg::OP_PUSH1:
            begin
                head_reg[lv_reg] <= pg_reg;
                h_reg            <= head_cur;
                t_reg            <= pg_reg;
            end
            bpa_pkg::OP_PUSHB1:
            begin
                head_reg[lv_reg] <= bd_reg;
                h_reg            <= head_cur;
                t_reg            <= bd_reg;
            end
            bpa_pkg::OP_FMARK:
                lv_reg <= (32'(rd_level_reg) > TOP_LEVEL) ? LW'(TOP_LEVEL) : rd_level_reg;
            bpa_pkg::OP_RD_BD:
                ux_reg <= AW'(fbd32);
            default:
            begin
            end
        endcase

        if (cmd.emit)
        begin
            out_status_reg <= cmd.st;
            out_page_reg   <= (cmd.st == bpa_pkg::ST_OK && kind_reg == bpa_pkg::REQ_ALLOC)
                            ? bpa_pkg::PAGE_W'(pg_reg) : '0;
            out_level_reg  <= (cmd.st == bpa_pkg::ST_OK &&
                               (kind_reg == bpa_pkg::REQ_ALLOC ||
                                kind_reg == bpa_pkg::REQ_FREE))
                            ? bpa_pkg::LEVEL_W'(lv_reg) : '0;
        end
    end

    assign sts.cnt_end     = 32'(cnt_reg) >= NUM_PAGES;
    assign sts.kind        = kind_reg;
    assign sts.zero        = zero_reg;
    assign sts.over        = over_reg;
    assign sts.pn_ok       = pn_ok_reg;
    assign sts.head_valid  = pg_ok(head_cur);
    assign sts.lv_top      = 32'(lv_reg) >= TOP_LEVEL;
    assign sts.lv_gt_want  = lv_reg > want_reg;
    assign sts.split_bd_ok = pg_ok(bd_reg);
    assign sts.rd_free     = rd_free_reg;
    assign sts.merge_ok    = rd_free_reg && (rd_level_reg == lv_reg);
    assign sts.free_bd_ok  = fbd32 < NUM_PAGES;
    assign sts.out_free    = out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_level_reg, out_page_reg};
    assign m_tuser  = out_status_reg;

`ifndef NO_ASSERTIONS
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == bpa_pkg::OP_TAKE) |-> pg_ok(head_cur))
        else $error("list head taken while empty");

    a_push_level: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == bpa_pkg::OP_PUSH1 || cmd.op == bpa_pkg::OP_PUSHB1)
        |-> (32'(lv_reg) <= TOP_LEVEL))
        else $error("push at level beyond top");

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("result overwritten before transfer");
`endif

endmodule

[rtl/bpa_ctrl.sv]
// Request sequencer for the buddy page allocator.
module bpa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output bpa_pkg::dp_cmd_t  cmd,
    input  bpa_pkg::dp_sts_t  sts
);

    typedef enum logic [4:0] {
        S_CLR0, S_CLR, S_BLK, S_BP1, S_BP2, S_BNX,
        S_IDLE, S_DISP, S_SCAN,
        S_SUL1, S_SUL2, S_SPL, S_SP1, S_SP2, S_SBD, S_SB2, S_SLOOP,
        S_PUL1, S_PUL2,
        S_FRD, S_FCHK, S_FLOOP, S_FCHK2, S_FUL2, S_FP1, S_FP2,
        S_EMIT
    } state_t;

    state_t                    state_reg, state_next;
    logic [bpa_pkg::ST_W-1:0]  code_reg, code_next;
    logic                      init_req_reg, init_req_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        code_next     = code_reg;
        init_req_next = init_req_reg;
        cmd.op        = bpa_pkg::OP_NONE;
        cmd.emit      = 1'b0;
        cmd.st        = code_reg;
        case (state_reg)
            S_CLR0:
            begin
                cmd.op     = bpa_pkg::OP_CLR_START;
                state_next = S_CLR;
            end
            S_CLR:
            begin
                if (sts.cnt_end)
                begin
                    cmd.op     = bpa_pkg::OP_BLK_START;
                    state_next = S_BLK;
                end
                else
                    cmd.op = bpa_pkg::OP_CLR_STEP;
            end
            S_BLK:
            begin
                if (sts.cnt_end)
                begin
                    if (init_req_reg)
                    begin
                        init_req_next = 1'b0;
                        code_next     = bpa_pkg::ST_OK;
                        state_next    = S_EMIT;
                    end
                    else
                        state_next = S_IDLE;
                end
                else
                begin
                    cmd.op     = bpa_pkg::OP_BLK_SETUP;
                    state_next = S_BP1;
                end
            end
            S_BP1:
            begin
                cmd.op     = bpa_pkg::OP_PUSH1;
                state_next = S_BP2;
            end
            S_BP2:
            begin
                cmd.op     = bpa_pkg::OP_PUSH2;
                state_next = S_BNX;
            end
            S_BNX:
            begin
                cmd.op     = bpa_pkg::OP_BLK_NEXT;
                state_next = S_BLK;
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op     = bpa_pkg::OP_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (sts.kind)
                    bpa_pkg::REQ_ALLOC:
                    begin
                        if (sts.zero)
                        begin
                            code_next  = bpa_pkg::ST_ZERO;
                            state_next = S_EMIT;
                        end
                        else if (sts.over)
                        begin
                            code_next  = bpa_pkg::ST_OOM;
                            state_next = S_EMIT;
                        end
                        else
                            state_next = S_SCAN;
                    end
                    bpa_pkg::REQ_FREE:
                    begin
                        if (sts.pn_ok)
                            state_next = S_FRD;
                        else
                        begin
                            code_next  = bpa_pkg::ST_IGN;
                            state_next = S_EMIT;
                        end
                    end
                    bpa_pkg::REQ_INIT:
                    begin
                        init_req_next = 1'b1;
                        state_next    = S_CLR0;
                    end
                    default:
                    begin
                        code_next  = bpa_pkg::ST_IGN;
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (sts.head_valid)
                begin
                    cmd.op     = bpa_pkg::OP_TAKE;
                    state_next = sts.lv_gt_want ? S_SUL1 : S_PUL1;
                end
                else if (sts.lv_top)
                begin
                    code_next  = bpa_pkg::ST_OOM;
                    state_next = S_EMIT;
                end
                else
                    cmd.op = bpa_pkg::OP_SCAN_UP;
            end
            S_SLOOP:
            begin
                cmd.op     = bpa_pkg::OP_TAKE;
                state_next = sts.lv_gt_want ? S_SUL1 : S_PUL1;
            end
            S_SUL1:
            begin
                cmd.op     = bpa_pkg::OP_UL1;
                state_next = S_SUL2;
            end
            S_SUL2:
            begin
                cmd.op     = bpa_pkg::OP_UL2;
                state_next = S_SPL;
            end
            S_SPL:
            begin
                cmd.op     = bpa_pkg::OP_SPLIT;
                state_next = S_SP1;
            end
            S_SP1:
            begin
                cmd.op     = bpa_pkg::OP_PUSH1;
                state_next = S_SP2;
            end
            S_SP2:
            begin
                cmd.op     = bpa_pkg::OP_PUSH2;
                state_next = S_SBD;
            end
            S_SBD:
            begin
                if (sts.split_bd_ok)
                begin
                    cmd.op     = bpa_pkg::OP_PUSHB1;
                    state_next = S_SB2;
                end
                else
                    state_next = S_SLOOP;
            end
            S_SB2:
            begin
                cmd.op     = bpa_pkg::OP_PUSH2;
                state_next = S_SLOOP;
            end
            S_PUL1:
            begin
                cmd.op     = bpa_pkg::OP_UL1;
                state_next = S_PUL2;
            end
            S_PUL2:
            begin
                cmd.op     = bpa_pkg::OP_UL2P;
                code_next  = bpa_pkg::ST_OK;
                state_next = S_EMIT;
            end
            S_FRD:
            begin
                cmd.op     = bpa_pkg::OP_RD_PG;
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                if (sts.rd_free)
                begin
                    code_next  = bpa_pkg::ST_IGN;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.op     = bpa_pkg::OP_FMARK;
                    state_next = S_FLOOP;
                end
            end
            S_FLOOP:
            begin
                if (sts.lv_top || !sts.free_bd_ok)
                    state_next = S_FP1;
                else
                begin
                    cmd.op     = bpa_pkg::OP_RD_BD;
                    state_next = S_FCHK2;
                end
            end
            S_FCHK2:
            begin
                if (sts.merge_ok)
                begin
                    cmd.op     = bpa_pkg::OP_UL1M;
                    state_next = S_FUL2;
                end
                else
                    state_next = S_FP1;
            end
            S_FUL2:
            begin
                cmd.op     = bpa_pkg::OP_UL2M;
                state_next = S_FLOOP;
            end
            S_FP1:
            begin
                cmd.op     = bpa_pkg::OP_PUSH1;
                state_next = S_FP2;
            end
            S_FP2:
            begin
                cmd.op     = bpa_pkg::OP_PUSH2;
                code_next  = bpa_pkg::ST_OK;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR0;
            code_reg     <= bpa_pkg::ST_OK;
            init_req_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            code_reg     <= code_next;
            init_req_reg <= init_req_next;
        end
    end

endmodule

[rtl/buddy_page_allocator_core.sv]
// Buddy page allocator: sequencer plus page-table datapath.
// Steps: allocate scans up the levels, then splits down, pushing the upper half when it is in range;
// free merges with its buddy while the buddy check passes; init clears every page, then pushes each block.
// Throughput: one request at a time; a new request is taken only in the idle state.
// Reset: runs a full init with heap start 256; no request transfer is taken until it
// finishes; config writes are always taken.
module buddy_page_allocator_core #(
    parameter int NUM_PAGES = 4096,
    parameter int TOP_LEVEL = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bpa_pkg::IN_DATA_W-1:0]   s_tdata,   // alloc_bytes, page_number, zero pad
    input  logic [bpa_pkg::REQ_W-1:0]       s_tuser,   // req_type
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bpa_pkg::OUT_DATA_W-1:0]  m_tdata,   // block_page, block_level
    output logic [bpa_pkg::ST_W-1:0]        m_tuser,   // status
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bpa_pkg::HEAP_W-1:0]      cfg_data   // heap_start_page
);

    bpa_pkg::dp_cmd_t cmd;
    bpa_pkg::dp_sts_t sts;

    assign cfg_ready = 1'b1;

    bpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    bpa_datapath #(
        .NUM_PAGES (NUM_PAGES),
        .TOP_LEVEL (TOP_LEVEL)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

[bench/tb_buddy_page_allocator_core.sv]
// Testbench for the buddy page allocator core: predicts each result and checks every transfer.
module tb_buddy_page_allocator_core;

    localparam int NPG = 4096;
    localparam int TOPLV = 12;
    localparam logic [12:0] NONE = 13'd4096;
    localparam logic [bpa_pkg::REQ_W-1:0] REQ_UNDEF = 2'd3;

    typedef struct packed {
        logic [bpa_pkg::ST_W-1:0]    status;
        logic [bpa_pkg::PAGE_W-1:0]  page;
        logic [bpa_pkg::LEVEL_W-1:0] level;
    } alloc_result_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [bpa_pkg::IN_DATA_W-1:0] s_tdata;
    logic [bpa_pkg::REQ_W-1:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [bpa_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [bpa_pkg::ST_W-1:0] m_tuser;
    logic cfg_valid;
    logic cfg_ready;
    logic [bpa_pkg::HEAP_W-1:0] cfg_data;

    buddy_page_allocator_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // allocator shadow state
    bit          pf_free [NPG];
    logic [3:0]  pf_level [NPG];
    logic [12:0] nxt [NPG];
    logic [12:0] prv [NPG];
    logic [12:0] head [TOPLV+1];
    logic [11:0] heap_base;

    alloc_result_t expected_results[$];
    int errors = 0;
    bit hold_sink = 0;
    int hold_cycles = 0;
    logic [11:0] live_blocks[$];

    initial begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial begin
        #20000000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic void list_push(logic [12:0] pg, int lv);
        nxt[pg] = head[lv];
        prv[pg] = NONE;
        if (head[lv] < NPG) prv[head[lv]] = pg;
        head[lv] = pg;
    endfunction

    function automatic void list_unlink(logic [12:0] pg, int lv);
        logic [12:0] nx;
        logic [12:0] pv;
        nx = nxt[pg];
        pv = prv[pg];
        if (nx < NPG) prv[nx] = pv;
        if (pv < NPG) nxt[pv] = nx;
        else head[lv] = nx;
        nxt[pg] = NONE;
        prv[pg] = NONE;
    endfunction

    function automatic void heap_init();
        int p;
        int lv;
        for (p = 0; p < NPG; p++) begin
            pf_free[p] = (p >= heap_base);
            pf_level[p] = 0;
            nxt[p] = NONE;
            prv[p] = NONE;
        end
        for (lv = 0; lv <= TOPLV; lv++) head[lv] = NONE;
        p = heap_base;
        while (p < NPG) begin
            lv = 0;
            while (lv < TOPLV && (p & ((2 << lv) - 1)) == 0 && p + (2 << lv) <= NPG) lv++;
            pf_level[p] = 4'(lv);
            list_push(13'(p), lv);
            p += 1 << lv;
        end
    endfunction

    function automatic alloc_result_t heap_alloc(logic [24:0] nbytes);
        alloc_result_t r;
        longint pages;
        int want;
        int lv;
        logic [12:0] pg;
        int bd;
        r = '0;
        if (nbytes == 0) begin
            r.status = bpa_pkg::ST_ZERO;
            return r;
        end
        pages = (longint'(nbytes) + 4095) >> bpa_pkg::PAGE_SHIFT;
        want = 0;
        while (want <= TOPLV && (longint'(1) << want) < pages) want++;
        if (want > TOPLV) begin
            r.status = bpa_pkg::ST_OOM;
            return r;
        end
        lv = want;
        while (lv <= TOPLV && head[lv] >= NPG) lv++;
        if (lv > TOPLV) begin
            r.status = bpa_pkg::ST_OOM;
            return r;
        end
        while (lv > want) begin
            pg = head[lv];
            list_unlink(pg, lv);
            lv--;
            bd = pg + (1 << lv);
            pf_level[pg] = 4'(lv);
            list_push(pg, lv);
            if (bd < NPG) begin
                pf_level[bd] = 4'(lv);
                pf_free[bd] = 1;
                list_push(13'(bd), lv);
            end
        end
        pg = head[want];
        list_unlink(pg, want);
        pf_free[pg] = 0;
        r.status = bpa_pkg::ST_OK;
        r.page = pg[11:0];
        r.level = 4'(want);
        return r;
    endfunction

    function automatic alloc_result_t heap_free(logic [11:0] pn);
        alloc_result_t r;
        int pg;
        int lv;
        int bd;
        r = '0;
        if (pn < heap_base || pf_free[pn]) begin
            r.status = bpa_pkg::ST_IGN;
            return r;
        end
        pg = pn;
        pf_free[pg] = 1;
        lv = pf_level[pg];
        if (lv > TOPLV) lv = TOPLV;
        while (lv < TOPLV) begin
            bd = pg ^ (1 << lv);
            if (bd >= NPG || !pf_free[bd] || pf_level[bd] != lv) break;
            list_unlink(13'(bd), lv);
            if (bd < pg) begin
                pf_level[pg] = 0;
                pg = bd;
            end else begin
                pf_level[bd] = 0;
            end
            lv++;
            pf_level[pg] = 4'(lv);
        end
        list_push(13'(pg), lv);
        r.status = bpa_pkg::ST_OK;
        r.level = 4'(lv);
        return r;
    endfunction

    function automatic alloc_result_t predict_request(logic [1:0] kind, logic [24:0] nbytes,
                                                      logic [11:0] pn);
        alloc_result_t r;
        r = '0;
        case (kind)
            bpa_pkg::REQ_ALLOC: r = heap_alloc(nbytes);
            bpa_pkg::REQ_FREE:  r = heap_free(pn);
            bpa_pkg::REQ_INIT:  heap_init();
            default:            r.status = bpa_pkg::ST_IGN;
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
        return $urandom_range(0, 3);
    endfunction

    // random idling only while hold_sink is clear
    initial begin
        int g;
        m_tready = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_sink) begin
                m_tready <= 0;
            end else if (m_tready && m_tvalid && $urandom_range(0, 2) != 0) begin
                m_tready <= 1;
            end else begin
                g = pick_gap();
                if (g == 0) m_tready <= 1;
                else begin
                    m_tready <= 0;
                    repeat (g - 1) @(negedge clk);
                    m_tready <= !hold_sink;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk) begin
        if (hold_sink) begin
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles >= 3000) begin
                hold_sink <= 0;
                hold_cycles <= 0;
            end
        end
    end

    always @(posedge clk) begin
        alloc_result_t got;
        alloc_result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got.status = m_tuser;
            got.page = m_tdata[11:0];
            got.level = m_tdata[15:12];
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result status=%0d page=%0d level=%0d",
                         $time, got.status, got.page, got.level);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                    errors++;
                end
                if (got.page !== want.page) begin
                    $display("%0t: block_page expected %0d actual %0d", $time, want.page, got.page);
                    errors++;
                end
                if (got.level !== want.level) begin
                    $display("%0t: block_level expected %0d actual %0d",
                             $time, want.level, got.level);
                    errors++;
                end
            end
        end
    end

    task automatic send_request(logic [1:0] kind, logic [24:0] nbytes, logic [11:0] pn,
                                bit with_gap = 1);
        int g;
        alloc_result_t r;
        if (with_gap) begin
            g = pick_gap();
            if (g > 0) begin
                s_tvalid <= 0;
                repeat (g) @(negedge clk);
            end
        end
        s_tvalid <= 1;
        s_tuser <= kind;
        s_tdata <= {3'b000, pn, nbytes};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        r = predict_request(kind, nbytes, pn);
        expected_results.push_back(r);
        if (kind == bpa_pkg::REQ_ALLOC && r.status == bpa_pkg::ST_OK) live_blocks.push_back(r.page);
        if (kind == bpa_pkg::REQ_INIT) live_blocks.delete();
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (expected_results.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic write_heap_base(logic [11:0] v);
        cfg_valid <= 1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        heap_base = v;
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    function automatic logic [24:0] rand_bytes();
        int sh;
        case ($urandom_range(0, 9))
            0: return 25'($urandom_range(1, 4096));
            1: return 25'($urandom());
            default: begin
                sh = $urandom_range(0, 13);
                return 25'($urandom_range(1, 4096 << sh));
            end
        endcase
    endfunction

    task automatic send_free_live();
        int i;
        logic [11:0] pg;
        i = $urandom_range(0, live_blocks.size() - 1);
        pg = live_blocks[i];
        live_blocks.delete(i);
        send_request(bpa_pkg::REQ_FREE, 25'd0, pg);
    endtask

    task automatic test_directed();
        send_request(bpa_pkg::REQ_ALLOC, 25'd0, 12'hFFF);
        send_request(bpa_pkg::REQ_ALLOC, 25'd1, 12'd0);
        send_request(bpa_pkg::REQ_ALLOC, 25'd4096, 12'd0);
        send_request(bpa_pkg::REQ_ALLOC, 25'd4097, 12'd0);
        send_request(bpa_pkg::REQ_ALLOC, 25'd16777216, 12'd0);
        send_request(bpa_pkg::REQ_ALLOC, 25'h1FFFFFF, 12'd0);
        send_request(bpa_pkg::REQ_ALLOC, 25'd16777215, 12'd0);
        send_request(bpa_pkg::REQ_ALLOC, 25'd8388608, 12'd0);
        send_request(bpa_pkg::REQ_FREE, 25'd0, 12'd0);
        send_request(bpa_pkg::REQ_FREE, 25'd0, 12'd255);
        send_request(bpa_pkg::REQ_FREE, 25'd0, 12'hFFF);
        send_request(REQ_UNDEF, 25'h1FFFFFF, 12'hFFF);
        while (live_blocks.size() > 0) send_free_live();
        send_request(bpa_pkg::REQ_FREE, 25'd0, 12'd256);
        send_request(bpa_pkg::REQ_INIT, 25'd0, 12'd0);
        send_request(bpa_pkg::REQ_ALLOC, 25'd12288, 12'd0);
        send_request(bpa_pkg::REQ_ALLOC, 25'd1048576, 12'd0);
        send_request(bpa_pkg::REQ_INIT, 25'd0, 12'd0);
        drain();
    endtask

    task automatic test_random_traffic(int count);
        int n;
        int sel;
        for (n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 45)
                send_request(bpa_pkg::REQ_ALLOC, rand_bytes(), 12'($urandom()));
            else if (sel < 85 && live_blocks.size() > 0)
                send_free_live();
            else if (sel < 95)
                send_request(bpa_pkg::REQ_FREE, 25'($urandom()), 12'($urandom()));
            else if (sel < 97)
                send_request(REQ_UNDEF, 25'($urandom()), 12'($urandom()));
            else
                send_request(bpa_pkg::REQ_INIT, 25'($urandom()), 12'($urandom()));
        end
    endtask

    task automatic test_back_pressure();
        int n;
        hold_sink = 1;
        for (n = 0; n < 30; n++)
            send_request(bpa_pkg::REQ_ALLOC, 25'($urandom_range(1, 65536)), 12'd0, 0);
        while (live_blocks.size() > 0) send_free_live();
        drain();
    endtask

    task automatic test_heap_base(logic [11:0] v, int count);
        write_heap_base(v);
        send_request(bpa_pkg::REQ_INIT, 25'd0, 12'd0);
        send_request(bpa_pkg::REQ_FREE, 25'd0, v == 0 ? 12'd0 : v - 12'd1);
        test_random_traffic(count);
        drain();
    endtask

    initial begin
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 0;
        cfg_data = '0;
        heap_base = bpa_pkg::HEAP_RESET;
        heap_init();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        test_directed();
        test_random_traffic(500);
        drain();
        test_back_pressure();
        test_heap_base(12'd0, 250);
        test_heap_base(12'hFFF, 60);
        test_heap_base(12'd1000, 250);
        // heap start moved without a new init
        write_heap_base(12'd2048);
        test_random_traffic(150);
        drain();
        test_heap_base(12'd256, 150);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[buddy_page_allocator_core.f]
rtl/bpa_pkg.sv
rtl/bpa_datapath.sv
rtl/bpa_ctrl.sv
rtl/buddy_page_allocator_core.sv
bench/tb_buddy_page_allocator_core.sv
